@@ hdl/hrrc_pkg.sv @@
// Package for the heart rate report conditioner.
// Register indexes, field widths and reset values; no dependencies.
package hrrc_pkg;

  // Field widths
  localparam int unsigned RATE_W   = 12;
  localparam int unsigned AVG_W    = 20;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned DEC_W    = 4;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 3;

  // Time arithmetic width default
  localparam int unsigned TIME_BITS_DEF = 32;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SETTLE_WINDOW = 3'd0,
    REG_REFRACTORY    = 3'd1,
    REG_RATE_MIN      = 3'd2,
    REG_RATE_MAX      = 3'd3,
    REG_PUBLISH_GAP   = 3'd4,
    REG_DECIM_LOG2    = 3'd5,
    REG_ALPHA         = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [MS_W-1:0]    SETTLE_RST  = 16'd3000;
  localparam logic [MS_W-1:0]    REFRACT_RST = 16'd250;
  localparam logic [RATE_W-1:0]  RMIN_RST    = 12'd640;
  localparam logic [RATE_W-1:0]  RMAX_RST    = 12'd2880;
  localparam logic [MS_W-1:0]    PUBLISH_RST = 16'd2000;
  localparam logic [DEC_W-1:0]   DECIM_RST   = 4'd4;
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd72;

  // Largest effective decimation exponent and alpha (1.0 in Q1.8)
  localparam logic [DEC_W-1:0]   DECIM_MAX = 4'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

endpackage

@@ hdl/hrrc_avg.sv @@
// Exponential average update for the rate conditioner.
// Uses hrrc_pkg widths; pure combinational, one signed multiply.
module hrrc_avg (
  input  logic [hrrc_pkg::AVG_W-1:0]   smoothed,
  input  logic [hrrc_pkg::RATE_W-1:0]  rate,
  input  logic [hrrc_pkg::ALPHA_W-1:0] alpha,
  output logic [hrrc_pkg::AVG_W-1:0]   smoothed_next
);

  logic [hrrc_pkg::AVG_W-1:0] rate_q;
  logic signed [20:0]         diff;
  logic signed [9:0]          alpha_s;
  logic signed [30:0]         prod;
  logic signed [30:0]         prod_sh;
  logic signed [22:0]         upd;

  // s' = ((256-a)*s + a*r) >> 8 = s + floor(a*(r-s)/256)
  always_comb begin
    rate_q  = {rate, 8'd0};
    diff    = $signed({1'b0, rate_q}) - $signed({1'b0, smoothed});
    alpha_s = $signed({1'b0, alpha});
    prod    = diff * alpha_s;
    prod_sh = prod >>> 8;
    upd     = $signed({3'b000, smoothed}) + $signed(prod_sh[22:0]);
    if (smoothed == '0) begin
      // not seeded yet: take the rate as is
      smoothed_next = rate_q;
    end else begin
      smoothed_next = upd[hrrc_pkg::AVG_W-1:0];
    end
  end

endmodule

@@ hdl/heart_rate_report_conditioner.sv @@
// Heart rate report conditioner top level: config registers, input stage,
// report decision and result register. Depends on hrrc_pkg and hrrc_avg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, now_ms .. rate_bpm      | into block
//  out     | out_valid/out_ready, sample_valid .. rate  | out of block
//  cfg     | cfg_we, cfg_index, cfg_data                | into block
//
// One item per cycle sustained while out_ready is high; an accepted item
// passes the input register, then decision plus average multiply into the
// result register. State is updated when an item moves into the result
// register, so the next item always sees it. A stalled output holds one
// result and one item in the input register, then in_ready drops.
// rst is synchronous and restores the register defaults and clears state.
module heart_rate_report_conditioner #(
  parameter int unsigned TIME_BITS = hrrc_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [hrrc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [hrrc_pkg::CFG_W-1:0]          cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hrrc_pkg::STAMP_W-1:0]        now_ms,
  input  logic [hrrc_pkg::STAMP_W-1:0]        leads_on_ms,
  input  logic signed [hrrc_pkg::SAMPLE_W-1:0] filtered_sample,
  input  logic                                beat_flag,
  input  logic [hrrc_pkg::RATE_W-1:0]         rate_bpm,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                sample_valid,
  output logic signed [hrrc_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                peak_valid,
  output logic [hrrc_pkg::RATE_W-1:0]         peak_rate,
  output logic                                smooth_valid,
  output logic [hrrc_pkg::RATE_W-1:0]         smooth_rate
);

  // configuration registers
  logic [hrrc_pkg::MS_W-1:0]    settle_window_ms;
  logic [hrrc_pkg::MS_W-1:0]    refractory_ms;
  logic [hrrc_pkg::RATE_W-1:0]  rate_min;
  logic [hrrc_pkg::RATE_W-1:0]  rate_max;
  logic [hrrc_pkg::MS_W-1:0]    publish_gap_ms;
  logic [hrrc_pkg::DEC_W-1:0]   decimation_log2;
  logic [hrrc_pkg::ALPHA_W-1:0] smoothing_alpha;

  // input stage
  logic                                 s1_valid;
  logic [hrrc_pkg::STAMP_W-1:0]         s1_now;
  logic [hrrc_pkg::STAMP_W-1:0]         s1_leads;
  logic signed [hrrc_pkg::SAMPLE_W-1:0] s1_sample;
  logic                                 s1_beat;
  logic [hrrc_pkg::RATE_W-1:0]          s1_rate;

  // block state
  logic [7:0]                 decimation_count;
  logic [TIME_BITS-1:0]       last_beat_ms;
  logic [TIME_BITS-1:0]       last_report_ms;
  logic [hrrc_pkg::AVG_W-1:0] smoothed_rate;

  // decision signals
  logic                                 go;
  logic [TIME_BITS-1:0]                 now_t;
  logic [TIME_BITS-1:0]                 leads_t;
  logic [TIME_BITS-1:0]                 el_leads;
  logic [TIME_BITS-1:0]                 el_beat;
  logic [TIME_BITS-1:0]                 el_report;
  logic                                 settling;
  logic                                 plausible;
  logic [hrrc_pkg::DEC_W-1:0]           dec_lg;
  logic [8:0]                           dec_span;
  logic [7:0]                           dec_mask;
  logic [hrrc_pkg::ALPHA_W-1:0]         alpha_eff;
  logic [hrrc_pkg::AVG_W-1:0]           avg_new;
  logic                                 take_beat;
  logic                                 upd_avg;
  logic                                 rep_peak;
  logic                                 rep_smooth;
  logic                                 samp_pass;

  // handshake: input register advances when the result slot frees up
  assign go       = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || go;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_window_ms <= hrrc_pkg::SETTLE_RST;
      refractory_ms    <= hrrc_pkg::REFRACT_RST;
      rate_min         <= hrrc_pkg::RMIN_RST;
      rate_max         <= hrrc_pkg::RMAX_RST;
      publish_gap_ms   <= hrrc_pkg::PUBLISH_RST;
      decimation_log2  <= hrrc_pkg::DECIM_RST;
      smoothing_alpha  <= hrrc_pkg::ALPHA_RST;
    end else if (cfg_we) begin
      unique case (hrrc_pkg::cfg_reg_t'(cfg_index))
        hrrc_pkg::REG_SETTLE_WINDOW: settle_window_ms <= cfg_data;
        hrrc_pkg::REG_REFRACTORY:    refractory_ms    <= cfg_data;
        hrrc_pkg::REG_RATE_MIN:      rate_min         <= cfg_data[hrrc_pkg::RATE_W-1:0];
        hrrc_pkg::REG_RATE_MAX:      rate_max         <= cfg_data[hrrc_pkg::RATE_W-1:0];
        hrrc_pkg::REG_PUBLISH_GAP:   publish_gap_ms   <= cfg_data;
        hrrc_pkg::REG_DECIM_LOG2:    decimation_log2  <= cfg_data[hrrc_pkg::DEC_W-1:0];
        hrrc_pkg::REG_ALPHA:         smoothing_alpha  <= cfg_data[hrrc_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now    <= now_ms;
      s1_leads  <= leads_on_ms;
      s1_sample <= filtered_sample;
      s1_beat   <= beat_flag;
      s1_rate   <= rate_bpm;
    end
  end

  // smoothing arithmetic
  hrrc_avg u_avg (
    .smoothed      (smoothed_rate),
    .rate          (s1_rate),
    .alpha         (alpha_eff),
    .smoothed_next (avg_new)
  );

  // report decision for the item in the input register
  always_comb begin
    now_t     = TIME_BITS'(s1_now);
    leads_t   = TIME_BITS'(s1_leads);
    el_leads  = now_t - leads_t;
    el_beat   = now_t - last_beat_ms;
    el_report = now_t - last_report_ms;

    dec_lg    = decimation_log2[3] ? hrrc_pkg::DECIM_MAX : decimation_log2;
    dec_span  = 9'd1 << dec_lg;
    dec_mask  = 8'(dec_span - 9'd1);
    samp_pass = (decimation_count & dec_mask) == 8'd0;

    alpha_eff = (smoothing_alpha > hrrc_pkg::ALPHA_ONE) ? hrrc_pkg::ALPHA_ONE
                                                         : smoothing_alpha;

    settling  = (s1_leads != '0) && (el_leads < TIME_BITS'(settle_window_ms));
    plausible = (s1_rate >= rate_min) && (s1_rate <= rate_max);

    // beat past the refractory gap moves last_beat_ms even if implausible
    take_beat  = !settling && s1_beat && !(el_beat < TIME_BITS'(refractory_ms));
    rep_peak   = take_beat && plausible;
    rep_smooth = rep_peak ||
                 (!settling && !s1_beat && plausible &&
                  (el_report > TIME_BITS'(publish_gap_ms)));
    upd_avg    = rep_smooth;
  end

  // state update as the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_count <= '0;
      last_beat_ms     <= '0;
      last_report_ms   <= '0;
      smoothed_rate    <= '0;
    end else if (go) begin
      decimation_count <= decimation_count + 8'd1;
      if (take_beat) begin
        last_beat_ms <= now_t;
      end
      if (upd_avg) begin
        smoothed_rate  <= avg_new;
        last_report_ms <= now_t;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sample_valid <= samp_pass;
      sample_out   <= samp_pass ? s1_sample : '0;
      peak_valid   <= rep_peak;
      peak_rate    <= rep_peak ? s1_rate : '0;
      smooth_valid <= rep_smooth;
      smooth_rate  <= rep_smooth ? avg_new[hrrc_pkg::AVG_W-1:8] : '0;
    end
  end

endmodule

@@ dv/hrrc_report_checker.sv @@
`timescale 1ns / 100ps
// Result checker for heart_rate_report_conditioner: tracks register writes,
// predicts one report per accepted sample and compares each result item.
// Depends on hrrc_pkg for widths, register indexes and reset values.
module hrrc_report_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hrrc_pkg::IDX_W-1:0]           cfg_index,
  input  logic [hrrc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [hrrc_pkg::STAMP_W-1:0]         now_ms,
  input  logic [hrrc_pkg::STAMP_W-1:0]         leads_on_ms,
  input  logic signed [hrrc_pkg::SAMPLE_W-1:0] filtered_sample,
  input  logic                                 beat_flag,
  input  logic [hrrc_pkg::RATE_W-1:0]          rate_bpm,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 sample_valid,
  input  logic signed [hrrc_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                 peak_valid,
  input  logic [hrrc_pkg::RATE_W-1:0]          peak_rate,
  input  logic                                 smooth_valid,
  input  logic [hrrc_pkg::RATE_W-1:0]          smooth_rate,
  output int                                   outstanding,
  output int                                   mismatches
);

  typedef struct packed {
    logic                          sample_valid;
    logic [hrrc_pkg::SAMPLE_W-1:0] sample_out;
    logic                          peak_valid;
    logic [hrrc_pkg::RATE_W-1:0]   peak_rate;
    logic                          smooth_valid;
    logic [hrrc_pkg::RATE_W-1:0]   smooth_rate;
  } report_t;

  // shadow copy of the register file
  logic [hrrc_pkg::MS_W-1:0]    settle_cfg;
  logic [hrrc_pkg::MS_W-1:0]    refract_cfg;
  logic [hrrc_pkg::RATE_W-1:0]  rmin_cfg;
  logic [hrrc_pkg::RATE_W-1:0]  rmax_cfg;
  logic [hrrc_pkg::MS_W-1:0]    gap_cfg;
  logic [hrrc_pkg::DEC_W-1:0]   decim_cfg;
  logic [hrrc_pkg::ALPHA_W-1:0] alpha_cfg;

  // predicted block state; average is Q12.8, zero means unseeded
  logic [7:0]                   decim_count;
  logic [hrrc_pkg::STAMP_W-1:0] last_beat;
  logic [hrrc_pkg::STAMP_W-1:0] last_report;
  logic [hrrc_pkg::AVG_W-1:0]   avg_q812;

  report_t expected_reports[$];
  report_t want;
  int      mismatch_tally = 0;

  // next value of the exponential average for a new rate
  function automatic logic [hrrc_pkg::AVG_W-1:0] blended_average(
    input logic [hrrc_pkg::RATE_W-1:0] rate
  );
    logic [39:0] a;
    logic [39:0] r8;
    logic [39:0] acc;
    a  = (alpha_cfg > hrrc_pkg::ALPHA_ONE) ? 40'(hrrc_pkg::ALPHA_ONE) : 40'(alpha_cfg);
    r8 = 40'(rate) << 8;
    if (avg_q812 == '0) return r8[hrrc_pkg::AVG_W-1:0];
    acc = ((40'd256 - a) * 40'(avg_q812) + a * r8) >> 8;
    return acc[hrrc_pkg::AVG_W-1:0];
  endfunction

  // one report per sample; updates the predicted state as the block would
  function automatic report_t predict_report(
    input logic [hrrc_pkg::STAMP_W-1:0]  now,
    input logic [hrrc_pkg::STAMP_W-1:0]  leads,
    input logic [hrrc_pkg::SAMPLE_W-1:0] sample,
    input logic                          beat,
    input logic [hrrc_pkg::RATE_W-1:0]   rate
  );
    report_t    r;
    logic [3:0] lg;
    logic [7:0] dmask;
    logic       plausible;
    r = '0;
    lg = (decim_cfg > hrrc_pkg::DECIM_MAX) ? hrrc_pkg::DECIM_MAX : decim_cfg;
    dmask = 8'((9'd1 << lg) - 9'd1);
    if ((decim_count & dmask) == 8'd0) begin
      r.sample_valid = 1'b1;
      r.sample_out   = sample;
    end
    decim_count = decim_count + 8'd1;

    // settle window after leads-on: sample path only
    if (leads != '0 && (now - leads) < {16'd0, settle_cfg}) return r;

    plausible = (rate >= rmin_cfg) && (rate <= rmax_cfg);
    if (beat) begin
      // refractory: beat ignored, nothing moves
      if ((now - last_beat) < {16'd0, refract_cfg}) return r;
      last_beat = now;
      if (plausible) begin
        avg_q812       = blended_average(rate);
        r.peak_valid   = 1'b1;
        r.peak_rate    = rate;
        r.smooth_valid = 1'b1;
        r.smooth_rate  = avg_q812[hrrc_pkg::AVG_W-1:8];
        last_report    = now;
      end
    end else if (plausible && (now - last_report) > {16'd0, gap_cfg}) begin
      avg_q812       = blended_average(rate);
      r.smooth_valid = 1'b1;
      r.smooth_rate  = avg_q812[hrrc_pkg::AVG_W-1:8];
      last_report    = now;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] exp_val,
                             input logic signed [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      mismatch_tally++;
    end
  endtask

  // watch config, result and sample channels
  always @(posedge clk) begin
    if (rst) begin
      settle_cfg  = hrrc_pkg::SETTLE_RST;
      refract_cfg = hrrc_pkg::REFRACT_RST;
      rmin_cfg    = hrrc_pkg::RMIN_RST;
      rmax_cfg    = hrrc_pkg::RMAX_RST;
      gap_cfg     = hrrc_pkg::PUBLISH_RST;
      decim_cfg   = hrrc_pkg::DECIM_RST;
      alpha_cfg   = hrrc_pkg::ALPHA_RST;
      decim_count = '0;
      last_beat   = '0;
      last_report = '0;
      avg_q812    = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hrrc_pkg::REG_SETTLE_WINDOW: settle_cfg  = cfg_data[hrrc_pkg::MS_W-1:0];
          hrrc_pkg::REG_REFRACTORY:    refract_cfg = cfg_data[hrrc_pkg::MS_W-1:0];
          hrrc_pkg::REG_RATE_MIN:      rmin_cfg    = cfg_data[hrrc_pkg::RATE_W-1:0];
          hrrc_pkg::REG_RATE_MAX:      rmax_cfg    = cfg_data[hrrc_pkg::RATE_W-1:0];
          hrrc_pkg::REG_PUBLISH_GAP:   gap_cfg     = cfg_data[hrrc_pkg::MS_W-1:0];
          hrrc_pkg::REG_DECIM_LOG2:    decim_cfg   = cfg_data[hrrc_pkg::DEC_W-1:0];
          hrrc_pkg::REG_ALPHA:         alpha_cfg   = cfg_data[hrrc_pkg::ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result item with no sample outstanding");
          mismatch_tally++;
        end else begin
          want = expected_reports.pop_front();
          check_field("sample_valid", 32'(want.sample_valid), 32'(sample_valid));
          check_field("sample_out", 32'($signed(want.sample_out)), 32'(sample_out));
          check_field("peak_valid", 32'(want.peak_valid), 32'(peak_valid));
          check_field("peak_rate", 32'(want.peak_rate), 32'(peak_rate));
          check_field("smooth_valid", 32'(want.smooth_valid), 32'(smooth_valid));
          check_field("smooth_rate", 32'(want.smooth_rate), 32'(smooth_rate));
        end
      end
      if (in_valid && in_ready)
        expected_reports.push_back(predict_report(now_ms, leads_on_ms, filtered_sample,
                                                  beat_flag, rate_bpm));
    end
    outstanding <= expected_reports.size();
    mismatches  <= mismatch_tally;
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Top of the heart_rate_report_conditioner testbench: clock, reset, sample
// stimulus, register settings and verdict. Needs hrrc_pkg and hrrc_report_checker.
module tb;

  localparam int unsigned PHASE_ITEMS = 106;

  typedef struct packed {
    logic [hrrc_pkg::MS_W-1:0]    settle;
    logic [hrrc_pkg::MS_W-1:0]    refract;
    logic [hrrc_pkg::RATE_W-1:0]  rmin;
    logic [hrrc_pkg::RATE_W-1:0]  rmax;
    logic [hrrc_pkg::MS_W-1:0]    gap;
    logic [hrrc_pkg::DEC_W-1:0]   decim;
    logic [hrrc_pkg::ALPHA_W-1:0] alpha;
  } setting_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_we;
  logic [hrrc_pkg::IDX_W-1:0]           cfg_index;
  logic [hrrc_pkg::CFG_W-1:0]           cfg_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [hrrc_pkg::STAMP_W-1:0]         now_ms;
  logic [hrrc_pkg::STAMP_W-1:0]         leads_on_ms;
  logic signed [hrrc_pkg::SAMPLE_W-1:0] filtered_sample;
  logic                                 beat_flag;
  logic [hrrc_pkg::RATE_W-1:0]          rate_bpm;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 sample_valid;
  logic signed [hrrc_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 peak_valid;
  logic [hrrc_pkg::RATE_W-1:0]          peak_rate;
  logic                                 smooth_valid;
  logic [hrrc_pkg::RATE_W-1:0]          smooth_rate;
  int                                   outstanding;
  int                                   mismatches;

  // stimulus state
  int unsigned                  send_idle_pct = 26;
  int unsigned                  recv_idle_pct = 71;
  setting_t                     cur;
  logic [hrrc_pkg::STAMP_W-1:0] clock_ms;
  logic [hrrc_pkg::STAMP_W-1:0] session_leads;

  heart_rate_report_conditioner uut (.*);
  hrrc_report_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic write_reg(input hrrc_pkg::cfg_reg_t idx,
                           input logic [hrrc_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(hrrc_pkg::REG_SETTLE_WINDOW, s.settle);
    write_reg(hrrc_pkg::REG_REFRACTORY, s.refract);
    write_reg(hrrc_pkg::REG_RATE_MIN, hrrc_pkg::CFG_W'(s.rmin));
    write_reg(hrrc_pkg::REG_RATE_MAX, hrrc_pkg::CFG_W'(s.rmax));
    write_reg(hrrc_pkg::REG_PUBLISH_GAP, s.gap);
    write_reg(hrrc_pkg::REG_DECIM_LOG2, hrrc_pkg::CFG_W'(s.decim));
    write_reg(hrrc_pkg::REG_ALPHA, hrrc_pkg::CFG_W'(s.alpha));
    cfg_we <= 1'b0;
    cur = s;
  endtask

  // one sample item, with random idle cycles ahead of it
  task automatic send_item(input logic [hrrc_pkg::STAMP_W-1:0] now,
                           input logic [hrrc_pkg::STAMP_W-1:0] leads,
                           input logic [hrrc_pkg::SAMPLE_W-1:0] sample, input logic beat,
                           input logic [hrrc_pkg::RATE_W-1:0] rate);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    now_ms          <= now;
    leads_on_ms     <= leads;
    filtered_sample <= sample;
    beat_flag       <= beat;
    rate_bpm        <= rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait for every report to come out
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly a running session: time moves on around the refractory and
  // publish thresholds, rates sit in the plausible range; some noise mixed in
  task automatic random_sample;
    int unsigned                  scale;
    int unsigned                  pick;
    int unsigned                  step;
    logic [hrrc_pkg::STAMP_W-1:0] leads;
    logic [hrrc_pkg::RATE_W-1:0]  rate;
    scale = (cur.refract > cur.gap) ? 32'(cur.refract) : 32'(cur.gap);
    if (scale < 300) scale = 300;
    pick = $urandom_range(0, 99);
    if (pick < 10) step = $urandom_range(0, 20);
    else if (pick < 85) step = $urandom_range(0, scale + scale / 2 + 50);
    else if (pick < 95) step = $urandom_range(0, 3 * scale + 32'(cur.settle) + 100);
    else step = $urandom;
    clock_ms = clock_ms + step;

    // leads-on: new session, leads off, or a stray value for one item
    pick = $urandom_range(0, 99);
    if (pick < 3) session_leads = clock_ms;
    else if (pick < 5) session_leads = '0;
    leads = (pick >= 5 && pick < 9) ? hrrc_pkg::STAMP_W'($urandom) : session_leads;

    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case (pick % 4)
        0: rate = cur.rmin;
        1: rate = cur.rmax;
        2: rate = cur.rmin - 1'b1;
        default: rate = cur.rmax + 1'b1;
      endcase
    end else if (pick < 80 && cur.rmin <= cur.rmax) begin
      rate = hrrc_pkg::RATE_W'($urandom_range(cur.rmax, cur.rmin));
    end else begin
      rate = hrrc_pkg::RATE_W'($urandom_range(0, 4095));
    end
    send_item(clock_ms, leads, hrrc_pkg::SAMPLE_W'($urandom),
              ($urandom_range(0, 99) < 40), rate);
  endtask

  initial begin
    setting_t s;
    int       p;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    now_ms          = '0;
    leads_on_ms     = '0;
    filtered_sample = '0;
    beat_flag       = 1'b0;
    rate_bpm        = '0;
    cur = '{hrrc_pkg::SETTLE_RST, hrrc_pkg::REFRACT_RST, hrrc_pkg::RMIN_RST,
            hrrc_pkg::RMAX_RST, hrrc_pkg::PUBLISH_RST, hrrc_pkg::DECIM_RST,
            hrrc_pkg::ALPHA_RST};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed run on reset settings
    send_item(32'd0, 32'd0, 16'h7fff, 1'b1, 12'd1200);       // inside refractory of time zero
    send_item(32'd1000, 32'd0, 16'h8000, 1'b1, 12'd1200);    // first beat seeds the average
    send_item(32'd1100, 32'd0, 16'h0000, 1'b1, 12'd1300);    // refractory
    send_item(32'd1400, 32'd0, 16'hffff, 1'b1, 12'd1300);    // average update
    send_item(32'd1700, 32'd0, 16'h0001, 1'b1, 12'd4095);    // implausible beat moves time
    send_item(32'd1800, 32'd0, 16'h1234, 1'b1, 12'd1000);    // refractory from that beat
    send_item(32'd2000, 32'd0, 16'h8001, 1'b0, 12'd1000);    // publish gap not reached
    send_item(32'd3401, 32'd0, 16'h7ffe, 1'b0, 12'd1000);    // gap just exceeded
    send_item(32'd5401, 32'd0, 16'h5555, 1'b0, 12'd1000);    // gap equal: no report
    send_item(32'd5402, 32'd0, 16'haaaa, 1'b0, 12'd640);     // rate at minimum
    send_item(32'd6000, 32'd0, 16'h0f0f, 1'b1, 12'd2880);    // rate at maximum
    send_item(32'd6300, 32'd0, 16'hf0f0, 1'b1, 12'd639);     // just below minimum
    send_item(32'd7000, 32'd7000, 16'h00ff, 1'b1, 12'd1200); // settle window start
    send_item(32'd9999, 32'd7000, 16'hff00, 1'b1, 12'd1200); // last settle ms
    send_item(32'd10000, 32'd7000, 16'h3c3c, 1'b1, 12'd1200); // settle over
    send_item(32'd10300, 32'd20000, 16'hc3c3, 1'b1, 12'd1200); // leads-on ahead of now
    send_item(32'hffff_ff00, 32'd0, 16'h6db6, 1'b1, 12'd2000);
    send_item(32'h0000_0010, 32'd0, 16'h9249, 1'b1, 12'd0);  // across the wrap, rate zero
    send_item(32'h0000_0100, 32'd0, 16'h2492, 1'b0, 12'd4095);
    send_item(32'hffff_ffff, 32'hffff_ffff, 16'hdb6d, 1'b1, 12'd1200);
    send_item(32'h0000_1000, 32'hffff_ffff, 16'h4000, 1'b0, 12'd1500);
    drain;

    // random phases over several register settings
    for (p = 0; p < 8; p++) begin
      case (p)
        0: s = '{16'd0, 16'd0, 12'd0, 12'd4095, 16'd0, 4'd0, 9'd0};
        1: s = '{16'hffff, 16'hffff, 12'd4095, 12'd4095, 16'hffff, 4'd15, 9'd511};
        2: s = '{16'd500, 16'd300, 12'd2000, 12'd1000, 16'd1500, 4'd3, 9'd128};
        3: s = '{16'd3000, 16'd250, 12'd640, 12'd2880, 16'd2000, 4'd8, 9'd256};
        default: begin
          s.settle  = hrrc_pkg::MS_W'($urandom_range(0, 6000));
          s.refract = hrrc_pkg::MS_W'($urandom_range(0, 1000));
          s.rmin    = hrrc_pkg::RATE_W'($urandom_range(0, 2000));
          s.rmax    = hrrc_pkg::RATE_W'($urandom_range(1000, 4095));
          s.gap     = hrrc_pkg::MS_W'($urandom_range(0, 5000));
          s.decim   = hrrc_pkg::DEC_W'($urandom_range(0, 15));
          s.alpha   = hrrc_pkg::ALPHA_W'($urandom_range(0, 511));
        end
      endcase
      if (p < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 71;
      end else if (p < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(s);
      clock_ms = $urandom;
      session_leads = $urandom_range(0, 1) ? '0 : clock_ms - $urandom_range(0, 100000);
      repeat (PHASE_ITEMS) random_sample();
      drain;
    end

    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
